// ===== rtl/core/triangle_mesh_area_volume_bounds_defines.svh =====
// assertion macros for the mesh statistics block
`ifndef TRIANGLE_MESH_AREA_VOLUME_BOUNDS_DEFINES_SVH
`define TRIANGLE_MESH_AREA_VOLUME_BOUNDS_DEFINES_SVH

// same-cycle implication, checked on the rising edge of clk outside reset
`define TMAVB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TMAVB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/tmavb_pkg.sv =====
// shared types and constants for the mesh statistics block
`timescale 1ns / 1ps
package tmavb_pkg;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MAC,
		ST_SQRT,
		ST_DIV,
		ST_DONE
	} state_t;

	// multiply-accumulate program, one entry per product
	typedef enum logic [4:0] {
		OP_N0_P, OP_N0_M, OP_N1_P, OP_N1_M, OP_N2_P, OP_N2_M,
		OP_B0_P, OP_B0_M, OP_B1_P, OP_B1_M, OP_B2_P, OP_B2_M,
		OP_T0, OP_T1, OP_T2,
		OP_S0, OP_S1, OP_S2
	} op_t;

	localparam int AREA_W  = 48;
	localparam int VOL_W   = 64;
	localparam int COUNT_W = 32;
	localparam int CNT_W   = 7;
	// divide by six in 16-bit digits, each by reciprocal multiply
	localparam int DIV_CHUNK = 16;
	localparam int DIV_STEPS = VOL_W / DIV_CHUNK;
	localparam int DIV_SHIFT = 21;
	localparam logic [2:0] DIVISOR = 3'd6;
	// ceil(2^21 / 6), exact for a partial dividend below 2^19
	localparam logic [DIV_CHUNK+2:0] DIV_RECIP = 19'd349526;
	localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic signed [VOL_W-1:0] VOL_POS_MAX = {1'b0, {(VOL_W-1){1'b1}}};
	localparam logic signed [VOL_W-1:0] VOL_NEG_MAX = {1'b1, {(VOL_W-1){1'b0}}};

endpackage

// ===== rtl/core/triangle_mesh_area_volume_bounds.sv =====
// mesh statistics: surface area, enclosed volume, bounding box, triangle count
//
//  channel | direction | handshake            | beat
//  in      | input     | in_valid / in_stall  | one triangle and its last flag
//  out     | output    | out_valid / out_stall| mesh totals, after the last triangle
//
// one shared shift-add multiply-accumulate unit runs 18 products in turn, each after its
// own operand load step, then a bit-serial square root with a 2*CW+2 bit result; a new
// beat is taken only after the previous triangle is done
// the last triangle adds a divide by six, one 16-bit digit per step, and then hands off the beat
// in_stall stays high from the accepted beat until the triangle (and its result) is done
// reset clears all sums, the count and the flag and sets the bounds to their extremes; no clearing pass is needed
`timescale 1ns / 1ps
`include "triangle_mesh_area_volume_bounds_defines.svh"
module triangle_mesh_area_volume_bounds
	import tmavb_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] first_x,
	input  logic signed [COORD_WIDTH-1:0] first_y,
	input  logic signed [COORD_WIDTH-1:0] first_z,
	input  logic signed [COORD_WIDTH-1:0] second_x,
	input  logic signed [COORD_WIDTH-1:0] second_y,
	input  logic signed [COORD_WIDTH-1:0] second_z,
	input  logic signed [COORD_WIDTH-1:0] third_x,
	input  logic signed [COORD_WIDTH-1:0] third_y,
	input  logic signed [COORD_WIDTH-1:0] third_z,
	input  logic                          last_triangle,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic        [AREA_W-1:0]      total_area,
	output logic signed [VOL_W-1:0]       mesh_volume,
	output logic signed [COORD_WIDTH-1:0] lower_x,
	output logic signed [COORD_WIDTH-1:0] lower_y,
	output logic signed [COORD_WIDTH-1:0] lower_z,
	output logic signed [COORD_WIDTH-1:0] upper_x,
	output logic signed [COORD_WIDTH-1:0] upper_y,
	output logic signed [COORD_WIDTH-1:0] upper_z,
	output logic        [COUNT_W-1:0]     triangle_total,
	output logic                          overflowed
);

	localparam int CW = COORD_WIDTH;
	localparam int EW = CW + 1;        // edge difference
	localparam int NW = 2 * CW + 3;    // cross product component
	localparam int AW = 4 * CW + 5;    // accumulator
	localparam int RW = 2 * CW + 2;    // square root result
	localparam int SW = 2 * RW;        // square root radicand
	localparam int DVW = DIV_CHUNK + 3; // partial dividend of one digit
	localparam logic signed [CW-1:0] COORD_POS_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] COORD_NEG_MAX = {1'b1, {(CW-1){1'b0}}};

	state_t state_q, state_d;
	op_t    op_q;

	logic [CNT_W-1:0] cnt_q, len_q;
	logic             neg_q;
	logic             last_q;
	logic signed [AW-1:0] m_q, acc_q, acc_nxt;
	logic signed [NW-1:0] q_q;
	logic signed [CW-1:0] a_q [3];
	logic signed [CW-1:0] b_q [3];
	logic signed [CW-1:0] c_q [3];
	logic signed [EW-1:0] e1_q [3];
	logic signed [EW-1:0] e2_q [3];
	logic signed [NW-1:0] n_q [3];
	logic signed [NW-1:0] bc_q [3];
	logic        [RW+1:0] rem_q;
	logic        [RW-1:0] root_q;
	logic        [AREA_W-1:0] area_q;
	logic signed [VOL_W-1:0]  vol_q;
	logic signed [CW-1:0] low_q [3];
	logic signed [CW-1:0] high_q [3];
	logic        [COUNT_W-1:0] count_q;
	logic        sat_q;
	logic [VOL_W-1:0]     dq_q;
	logic [2:0]           dr_q;
	logic                 vneg_q;

	logic signed [CW-1:0] in_a [3];
	logic signed [CW-1:0] in_b [3];
	logic signed [CW-1:0] in_c [3];
	logic signed [CW-1:0] tri_lo [3];
	logic signed [CW-1:0] tri_hi [3];

	logic signed [AW-1:0] ld_m;
	logic signed [NW-1:0] ld_q;
	logic [CNT_W-1:0]     ld_len;
	logic                 ld_clr, ld_neg;

	logic       in_acc, mac_end, sqrt_end, div_end;
	logic       sub_now;
	logic [RW+1:0] sq_rem_n, sq_trial;
	logic [RW+1:0] sq_rem_nxt;
	logic [RW-1:0] sq_root_nxt;
	logic [AREA_W:0] area_sum_w;
	logic signed [VOL_W:0] vol_sum_w;
	logic [DVW-1:0] dv_t;
	logic [2*DVW-1:0] dv_prod;
	logic [DIV_CHUNK-1:0] dv_quo;
	logic [VOL_W-1:0] dq_nxt;
	logic [2:0] dr_nxt;

	assign in_a[0] = first_x;  assign in_a[1] = first_y;  assign in_a[2] = first_z;
	assign in_b[0] = second_x; assign in_b[1] = second_y; assign in_b[2] = second_z;
	assign in_c[0] = third_x;  assign in_c[1] = third_y;  assign in_c[2] = third_z;

	// per-axis min and max of the incoming triangle
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			tri_lo[k] = in_a[k];
			tri_hi[k] = in_a[k];
			if (in_b[k] < tri_lo[k]) tri_lo[k] = in_b[k];
			if (in_c[k] < tri_lo[k]) tri_lo[k] = in_c[k];
			if (in_b[k] > tri_hi[k]) tri_hi[k] = in_b[k];
			if (in_c[k] > tri_hi[k]) tri_hi[k] = in_c[k];
		end
	end

	// operand selection for the next product
	always_comb begin
		ld_m   = '0;
		ld_q   = '0;
		ld_len = CNT_W'(EW);
		ld_clr = 1'b0;
		ld_neg = 1'b0;
		unique case (op_q)
			OP_N0_P: begin
				ld_m = AW'(e1_q[1]); ld_q = NW'(e2_q[2]); ld_clr = 1'b1;
			end
			OP_N0_M: begin
				ld_m = AW'(e1_q[2]); ld_q = NW'(e2_q[1]); ld_neg = 1'b1;
			end
			OP_N1_P: begin
				ld_m = AW'(e1_q[2]); ld_q = NW'(e2_q[0]); ld_clr = 1'b1;
			end
			OP_N1_M: begin
				ld_m = AW'(e1_q[0]); ld_q = NW'(e2_q[2]); ld_neg = 1'b1;
			end
			OP_N2_P: begin
				ld_m = AW'(e1_q[0]); ld_q = NW'(e2_q[1]); ld_clr = 1'b1;
			end
			OP_N2_M: begin
				ld_m = AW'(e1_q[1]); ld_q = NW'(e2_q[0]); ld_neg = 1'b1;
			end
			OP_B0_P: begin
				ld_m = AW'(b_q[1]); ld_q = NW'(c_q[2]); ld_clr = 1'b1;
				ld_len = CNT_W'(CW);
			end
			OP_B0_M: begin
				ld_m = AW'(b_q[2]); ld_q = NW'(c_q[1]); ld_neg = 1'b1;
				ld_len = CNT_W'(CW);
			end
			OP_B1_P: begin
				ld_m = AW'(b_q[2]); ld_q = NW'(c_q[0]); ld_clr = 1'b1;
				ld_len = CNT_W'(CW);
			end
			OP_B1_M: begin
				ld_m = AW'(b_q[0]); ld_q = NW'(c_q[2]); ld_neg = 1'b1;
				ld_len = CNT_W'(CW);
			end
			OP_B2_P: begin
				ld_m = AW'(b_q[0]); ld_q = NW'(c_q[1]); ld_clr = 1'b1;
				ld_len = CNT_W'(CW);
			end
			OP_B2_M: begin
				ld_m = AW'(b_q[1]); ld_q = NW'(c_q[0]); ld_neg = 1'b1;
				ld_len = CNT_W'(CW);
			end
			OP_T0: begin
				ld_m = AW'(bc_q[0]); ld_q = NW'(a_q[0]); ld_clr = 1'b1;
				ld_len = CNT_W'(CW);
			end
			OP_T1: begin
				ld_m = AW'(bc_q[1]); ld_q = NW'(a_q[1]); ld_len = CNT_W'(CW);
			end
			OP_T2: begin
				ld_m = AW'(bc_q[2]); ld_q = NW'(a_q[2]); ld_len = CNT_W'(CW);
			end
			OP_S0: begin
				ld_m = AW'(n_q[0]); ld_q = n_q[0]; ld_clr = 1'b1;
				ld_len = CNT_W'(NW);
			end
			OP_S1: begin
				ld_m = AW'(n_q[1]); ld_q = n_q[1]; ld_len = CNT_W'(NW);
			end
			OP_S2: begin
				ld_m = AW'(n_q[2]); ld_q = n_q[2]; ld_len = CNT_W'(NW);
			end
			default: begin
				ld_m = '0;
			end
		endcase
	end

	// shared shift-add step; the top multiplier bit carries negative weight
	assign sub_now = (cnt_q == len_q - CNT_W'(1)) ^ neg_q;
	always_comb begin
		acc_nxt = acc_q;
		if (q_q[0]) begin
			acc_nxt = sub_now ? acc_q - m_q : acc_q + m_q;
		end
	end

	// one digit of the square root recurrence
	always_comb begin
		sq_rem_n    = {rem_q[RW-1:0], acc_q[SW-1 -: 2]};
		sq_trial    = {root_q, 2'b01};
		sq_rem_nxt  = sq_rem_n;
		sq_root_nxt = {root_q[RW-2:0], 1'b0};
		if (sq_rem_n >= sq_trial) begin
			sq_rem_nxt  = sq_rem_n - sq_trial;
			sq_root_nxt = {root_q[RW-2:0], 1'b1};
		end
	end

	// one 16-bit quotient digit of the divide by six
	always_comb begin
		dv_t    = {dr_q, dq_q[VOL_W-1 -: DIV_CHUNK]};
		dv_prod = (2 * DVW)'(dv_t) * (2 * DVW)'(DIV_RECIP);
		dv_quo  = dv_prod[DIV_SHIFT +: DIV_CHUNK];
		dr_nxt  = 3'(dv_t - DVW'(dv_quo) * DVW'(DIVISOR));
		dq_nxt  = {dq_q[VOL_W-DIV_CHUNK-1:0], dv_quo};
	end

	assign area_sum_w = {1'b0, area_q} + (AREA_W + 1)'(sq_root_nxt[RW-1:1]);
	assign vol_sum_w  = (VOL_W + 1)'(vol_q) + (VOL_W + 1)'(acc_nxt);

	assign in_acc   = in_valid && !in_stall;
	assign mac_end  = (state_q == ST_MAC) && (cnt_q == len_q - CNT_W'(1));
	assign sqrt_end = (state_q == ST_SQRT) && (cnt_q == CNT_W'(RW - 1));
	assign div_end  = (state_q == ST_DIV) && (cnt_q == CNT_W'(DIV_STEPS - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_acc) state_d = ST_LOAD;
			ST_LOAD: state_d = ST_MAC;
			ST_MAC: begin
				if (mac_end) state_d = (op_q == OP_S2) ? ST_SQRT : ST_LOAD;
			end
			ST_SQRT: begin
				if (sqrt_end) state_d = last_q ? ST_DIV : ST_IDLE;
			end
			ST_DIV: if (div_end) state_d = ST_DONE;
			ST_DONE: if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		out_valid = (state_q == ST_DONE);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer and mesh accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= OP_N0_P;
			cnt_q   <= '0;
			len_q   <= '0;
			neg_q   <= 1'b0;
			last_q  <= 1'b0;
			area_q  <= '0;
			vol_q   <= '0;
			count_q <= '0;
			sat_q   <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				low_q[k]  <= COORD_POS_MAX;
				high_q[k] <= COORD_NEG_MAX;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						op_q   <= OP_N0_P;
						last_q <= last_triangle;
						for (int k = 0; k < 3; k++) begin
							if (tri_lo[k] < low_q[k]) low_q[k] <= tri_lo[k];
							if (tri_hi[k] > high_q[k]) high_q[k] <= tri_hi[k];
						end
						if (count_q == COUNT_MAX) begin
							sat_q <= 1'b1;
						end else begin
							count_q <= count_q + COUNT_W'(1);
						end
					end
				end
				ST_LOAD: begin
					cnt_q <= '0;
					len_q <= ld_len;
					neg_q <= ld_neg;
				end
				ST_MAC: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (mac_end) begin
						cnt_q <= '0;
						if (op_q != OP_S2) op_q <= op_t'(op_q + 5'd1);
						if (op_q == OP_T2) begin
							// saturating add of the triple product
							if (vol_sum_w[VOL_W] != vol_sum_w[VOL_W-1]) begin
								vol_q <= vol_sum_w[VOL_W] ? VOL_NEG_MAX : VOL_POS_MAX;
								sat_q <= 1'b1;
							end else begin
								vol_q <= vol_sum_w[VOL_W-1:0];
							end
						end
					end
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (sqrt_end) begin
						cnt_q <= '0;
						if (area_sum_w[AREA_W]) begin
							area_q <= AREA_MAX;
							sat_q  <= 1'b1;
						end else begin
							area_q <= area_sum_w[AREA_W-1:0];
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (div_end) begin
						// totals move to the output beat, mesh state starts over
						cnt_q   <= '0;
						area_q  <= '0;
						vol_q   <= '0;
						count_q <= '0;
						sat_q   <= 1'b0;
						for (int k = 0; k < 3; k++) begin
							low_q[k]  <= COORD_POS_MAX;
							high_q[k] <= COORD_NEG_MAX;
						end
					end
				end
				ST_DONE: begin
					cnt_q <= '0;
				end
				default: begin
					cnt_q <= '0;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					for (int k = 0; k < 3; k++) begin
						a_q[k]  <= in_a[k];
						b_q[k]  <= in_b[k];
						c_q[k]  <= in_c[k];
						e1_q[k] <= EW'(in_b[k]) - EW'(in_a[k]);
						e2_q[k] <= EW'(in_c[k]) - EW'(in_a[k]);
					end
				end
			end
			ST_LOAD: begin
				m_q <= ld_m;
				q_q <= ld_q;
				if (ld_clr) acc_q <= '0;
			end
			ST_MAC: begin
				acc_q <= acc_nxt;
				m_q   <= m_q <<< 1;
				q_q   <= q_q >>> 1;
				if (mac_end) begin
					unique case (op_q)
						OP_N0_M: n_q[0]  <= acc_nxt[NW-1:0];
						OP_N1_M: n_q[1]  <= acc_nxt[NW-1:0];
						OP_N2_M: n_q[2]  <= acc_nxt[NW-1:0];
						OP_B0_M: bc_q[0] <= acc_nxt[NW-1:0];
						OP_B1_M: bc_q[1] <= acc_nxt[NW-1:0];
						OP_B2_M: bc_q[2] <= acc_nxt[NW-1:0];
						OP_S2: begin
							rem_q  <= '0;
							root_q <= '0;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SQRT: begin
				acc_q  <= acc_q <<< 2;
				rem_q  <= sq_rem_nxt;
				root_q <= sq_root_nxt;
				if (sqrt_end) begin
					dq_q   <= vol_q[VOL_W-1] ? VOL_W'(-vol_q) : VOL_W'(vol_q);
					vneg_q <= vol_q[VOL_W-1];
					dr_q   <= '0;
				end
			end
			ST_DIV: begin
				dq_q <= dq_nxt;
				dr_q <= dr_nxt;
				if (div_end) begin
					total_area      <= area_q;
					mesh_volume     <= vneg_q ? -$signed(dq_nxt) : $signed(dq_nxt);
					lower_x         <= low_q[0];
					lower_y         <= low_q[1];
					lower_z         <= low_q[2];
					upper_x         <= high_q[0];
					upper_y         <= high_q[1];
					upper_z         <= high_q[2];
					triangle_total  <= count_q;
					overflowed      <= sat_q;
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// checks
	`TMAVB_ASSERT_NOW(a_out_blocks_in, out_valid, in_stall, "input taken while result pending")
	`TMAVB_ASSERT_NEXT(a_in_no_result, in_valid && !in_stall, !out_valid, "result right after beat")
	`TMAVB_ASSERT_NEXT(a_out_once, out_valid && !out_stall, !out_valid, "result beat repeated")
	`TMAVB_ASSERT_NOW(a_div_only_last, state_q == ST_DIV, last_q, "divide on a non-last triangle")

endmodule
